// ----- hdl/mwsm_pkg.sv -----
// ----------------------------------------------------------------------------
// mwsm_pkg: shared types and constants of the mecanum wheel speed mixer
// Field widths, internal datapath widths, pipeline depth and register indexes.
// ----------------------------------------------------------------------------
package mwsm_pkg;

  // Port field widths
  localparam int unsigned VEL_W   = 12;
  localparam int unsigned YAW_W   = 13;
  localparam int unsigned BASE_W  = 8;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned LIM_W   = 15;
  localparam int unsigned MOT_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Internal datapath widths
  localparam int unsigned LANES   = 4;
  localparam int unsigned SUM_W   = 14;  // +-(vx +- vy), exact
  localparam int unsigned ROT_W   = 21;  // yaw_rate * wheel_base_sum, Q.8
  localparam int unsigned LIN_W   = 22;  // wheel surface speed, Q.8
  localparam int unsigned FRAC_W  = 16;  // fraction bits after gain multiply
  localparam int unsigned PROD_W  = 38;  // wheel speed times gain, Q.16
  localparam int unsigned WHL_W   = PROD_W - FRAC_W;  // signed motor rpm
  localparam int unsigned MAG_W   = WHL_W - 1;        // motor rpm magnitude
  localparam int unsigned NUM_W   = MAG_W + LIM_W;    // magnitude times limit

  // One quotient bit per divider step
  localparam int unsigned DIV_STEPS  = MAG_W;
  // sum, wheel, gain, truncate, magnitude, rescale setup, divider, output
  localparam int unsigned ST_DIV0    = 6;
  localparam int unsigned PIPE_DEPTH = ST_DIV0 + DIV_STEPS + 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WHEEL_BASE_SUM    = 2'd0,
    REG_SPEED_GAIN        = 2'd1,
    REG_MOTOR_SPEED_LIMIT = 2'd2
  } cfg_reg_e;

  // Register reset values
  localparam logic [BASE_W-1:0] WHEEL_BASE_SUM_RST    = 8'd40;
  localparam logic [GAIN_W-1:0] SPEED_GAIN_RST        = 16'd6144;
  localparam logic [LIM_W-1:0]  MOTOR_SPEED_LIMIT_RST = 15'd8000;

endpackage

// ----- hdl/mecanum_wheel_speed_mixer.sv -----
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_mixer: body velocity command to four motor rpm targets
// Mixes forward, sideways and yaw commands into mecanum wheel speeds, scales
// them to motor rpm, rescales against a limit and saturates to 16 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: vel_x_i, vel_y_i, yaw_rate_i with in_valid_i/in_stall_o.
//   A transfer happens on a clock edge with in_valid_i high and in_stall_o low.
//   Result channel: motor_a_o..motor_d_o with out_valid_o/out_stall_i, one
//   result per command, in order.
//   Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   cfg_ready_o is always high. Write registers only while the block is empty.
//   Depth: 28 register stages from the command transfer to out_valid_o. One
//   command enters every cycle while in_stall_o is low; the depth is set by the
//   21-step restoring divider (one quotient bit per stage) for the rescale.
//   Stall: out_stall_i holds the output register; stages behind it keep
//   advancing into empty slots, and in_stall_o rises only once every stage
//   holds a command.
//   Reset: all stages empty, registers at their reset values.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_mixer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Command channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [mwsm_pkg::VEL_W-1:0] vel_x_i,
  input  logic signed [mwsm_pkg::VEL_W-1:0] vel_y_i,
  input  logic signed [mwsm_pkg::YAW_W-1:0] yaw_rate_i,
  // Result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [mwsm_pkg::MOT_W-1:0] motor_a_o,
  output logic signed [mwsm_pkg::MOT_W-1:0] motor_b_o,
  output logic signed [mwsm_pkg::MOT_W-1:0] motor_c_o,
  output logic signed [mwsm_pkg::MOT_W-1:0] motor_d_o,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mwsm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mwsm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mwsm_pkg::*;

  // Configuration registers
  logic [BASE_W-1:0] base_q;
  logic [GAIN_W-1:0] gain_q;
  logic [LIM_W-1:0]  lim_q;

  // Pipeline control
  logic [PIPE_DEPTH:1]   valid_q;
  logic [PIPE_DEPTH:1]   valid_d;
  logic [PIPE_DEPTH-1:0] valid_up;
  logic [PIPE_DEPTH:1]   adv;

  // Stage 1: linear sums and rotation term
  logic signed [SUM_W-1:0] sum_q [LANES];
  logic signed [SUM_W-1:0] sum_d [LANES];
  logic signed [ROT_W-1:0] rot_q;
  logic signed [ROT_W:0]   rot_full;
  logic signed [SUM_W-1:0] vx_ext;
  logic signed [SUM_W-1:0] vy_ext;

  // Stage 2: wheel surface speeds (lanes two and four already negated)
  logic signed [LIN_W-1:0] lin_q [LANES];
  logic signed [LIN_W-1:0] lin_d [LANES];

  // Stage 3: speed times gain
  logic signed [PROD_W-1:0] prod_q [LANES];
  logic signed [PROD_W:0]   prod_full [LANES];

  // Stage 4: motor rpm truncated toward zero
  logic signed [WHL_W-1:0]  whl_q [LANES];
  logic signed [WHL_W-1:0]  whl_d [LANES];
  logic signed [PROD_W-1:0] bias_sum [LANES];

  // Stage 5: magnitudes, signs and pairwise maxima
  logic [MAG_W-1:0]        mag_q [LANES];
  logic [MAG_W-1:0]        mag_d [LANES];
  logic [LANES-1:0]        sgn5_q;
  logic signed [WHL_W-1:0] max01_q;
  logic signed [WHL_W-1:0] max23_q;
  logic signed [WHL_W-1:0] neg_whl [LANES];

  // Stage 6 and divider steps: partial remainder, remaining dividend bits,
  // quotient bits, divisor and lane signs
  logic [MAG_W-1:0] rem_q [DIV_STEPS+1][LANES];
  logic [MAG_W-1:0] nlo_q [DIV_STEPS+1][LANES];
  logic [MAG_W-1:0] quo_q [DIV_STEPS+1][LANES];
  logic [MAG_W-1:0] den_q [DIV_STEPS+1];
  logic [LANES-1:0] sgn_q [DIV_STEPS+1];

  // Stage 6 combinational terms
  logic signed [WHL_W-1:0] max_all;
  logic                    rescale;
  logic [NUM_W-1:0]        num [LANES];
  logic [NUM_W-1:0]        scaled [LANES];

  // Output stage
  logic signed [MOT_W-1:0] motor_q [LANES];
  logic signed [MOT_W-1:0] motor_d [LANES];

  // --------------------------------------------------------------------------
  // Configuration write port
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= WHEEL_BASE_SUM_RST;
      gain_q <= SPEED_GAIN_RST;
      lim_q  <= MOTOR_SPEED_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_WHEEL_BASE_SUM:    base_q <= cfg_data_i[BASE_W-1:0];
        REG_SPEED_GAIN:        gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_MOTOR_SPEED_LIMIT: lim_q  <= cfg_data_i[LIM_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Valid chain: a stage advances when it is empty or the next one advances
  // --------------------------------------------------------------------------
  assign valid_up = {valid_q[PIPE_DEPTH-1:1], in_valid_i};
  assign adv[PIPE_DEPTH] = !valid_q[PIPE_DEPTH] || !out_stall_i;

  for (genvar k = 1; k < PIPE_DEPTH; k++) begin : g_adv
    assign adv[k] = !valid_q[k] || adv[k+1];
  end

  for (genvar k = 1; k <= PIPE_DEPTH; k++) begin : g_valid
    assign valid_d[k] = adv[k] ? valid_up[k-1] : valid_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !adv[1];
  assign out_valid_o = valid_q[PIPE_DEPTH];

  // --------------------------------------------------------------------------
  // Stage 1: form +-(vx +- vy) per lane and yaw_rate * wheel_base_sum
  // --------------------------------------------------------------------------
  assign vx_ext   = SUM_W'(vel_x_i);
  assign vy_ext   = SUM_W'(vel_y_i);
  assign rot_full = yaw_rate_i * $signed({1'b0, base_q});

  always_comb begin
    sum_d[0] = vx_ext + vy_ext;
    sum_d[1] = vy_ext - vx_ext;
    sum_d[2] = vx_ext - vy_ext;
    sum_d[3] = -vx_ext - vy_ext;
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      sum_q <= sum_d;
      rot_q <= rot_full[ROT_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: wheel speed in Q.8, sum * 256 + rotation
  // --------------------------------------------------------------------------
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lin_d[l] = $signed({sum_q[l], 8'd0}) + LIN_W'(rot_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      lin_q <= lin_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: multiply by the Q8.8 gain
  // --------------------------------------------------------------------------
  for (genvar l = 0; l < LANES; l++) begin : g_gain
    assign prod_full[l] = lin_q[l] * $signed({1'b0, gain_q});

    always_ff @(posedge clk_i) begin
      if (adv[3]) begin
        prod_q[l] <= prod_full[l][PROD_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: drop the fraction, rounding toward zero
  // --------------------------------------------------------------------------
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      bias_sum[l] = prod_q[l] + PROD_W'({FRAC_W{prod_q[l][PROD_W-1]}});
      whl_d[l]    = bias_sum[l][PROD_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      whl_q <= whl_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: split into sign and magnitude, start the maximum search
  // --------------------------------------------------------------------------
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      neg_whl[l] = -whl_q[l];
      mag_d[l]   = whl_q[l][WHL_W-1] ? neg_whl[l][MAG_W-1:0] : whl_q[l][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      mag_q   <= mag_d;
      for (int l = 0; l < LANES; l++) begin
        sgn5_q[l] <= whl_q[l][WHL_W-1];
      end
      max01_q <= (whl_q[1] > whl_q[0]) ? whl_q[1] : whl_q[0];
      max23_q <= (whl_q[3] > whl_q[2]) ? whl_q[3] : whl_q[2];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: decide on rescaling and set up the dividers. Without rescaling
  // divide the magnitude by one so that the result passes through unchanged.
  // --------------------------------------------------------------------------
  assign max_all = (max23_q > max01_q) ? max23_q : max01_q;
  assign rescale = max_all > $signed(WHL_W'(lim_q));

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      scaled[l] = mag_q[l] * lim_q;
      num[l]    = rescale ? scaled[l] : NUM_W'(mag_q[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_DIV0]) begin
      for (int l = 0; l < LANES; l++) begin
        rem_q[0][l] <= MAG_W'(num[l][NUM_W-1:MAG_W]);
        nlo_q[0][l] <= num[l][MAG_W-1:0];
        quo_q[0][l] <= '0;
      end
      den_q[0] <= rescale ? max_all[MAG_W-1:0] : MAG_W'(1);
      sgn_q[0] <= sgn5_q;
    end
  end

  // --------------------------------------------------------------------------
  // Divider steps: shift in one dividend bit, subtract when it fits
  // --------------------------------------------------------------------------
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [MAG_W:0]   trial [LANES];
    logic [MAG_W:0]   diff  [LANES];
    logic [LANES-1:0] fits;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_q[j-1][l], nlo_q[j-1][l][MAG_W-1]};
        diff[l]  = trial[l] - {1'b0, den_q[j-1]};
        fits[l]  = trial[l] >= {1'b0, den_q[j-1]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[ST_DIV0+j]) begin
        for (int l = 0; l < LANES; l++) begin
          rem_q[j][l] <= fits[l] ? diff[l][MAG_W-1:0] : trial[l][MAG_W-1:0];
          nlo_q[j][l] <= {nlo_q[j-1][l][MAG_W-2:0], 1'b0};
          quo_q[j][l] <= {quo_q[j-1][l][MAG_W-2:0], fits[l]};
        end
        den_q[j] <= den_q[j-1];
        sgn_q[j] <= sgn_q[j-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: restore the sign and saturate to 16 bits
  // --------------------------------------------------------------------------
  localparam logic [MAG_W-1:0] POS_MAX = MAG_W'(2**(MOT_W-1) - 1);
  localparam logic [MAG_W-1:0] NEG_MAX = MAG_W'(2**(MOT_W-1));

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (sgn_q[DIV_STEPS][l]) begin
        if (quo_q[DIV_STEPS][l] > NEG_MAX) begin
          motor_d[l] = {1'b1, {(MOT_W-1){1'b0}}};
        end else begin
          motor_d[l] = -$signed(quo_q[DIV_STEPS][l][MOT_W-1:0]);
        end
      end else begin
        if (quo_q[DIV_STEPS][l] > POS_MAX) begin
          motor_d[l] = {1'b0, {(MOT_W-1){1'b1}}};
        end else begin
          motor_d[l] = $signed(quo_q[DIV_STEPS][l][MOT_W-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[PIPE_DEPTH]) begin
      motor_q <= motor_d;
    end
  end

  assign motor_a_o = motor_q[0];
  assign motor_b_o = motor_q[1];
  assign motor_c_o = motor_q[2];
  assign motor_d_o = motor_q[3];

endmodule

// ----- hdl/mwsm_chk.sv -----
// ----------------------------------------------------------------------------
// mwsm_chk: port-level checks for the mecanum wheel speed mixer
// Watches the handshake ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module mwsm_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [mwsm_pkg::MOT_W-1:0] motor_a_o,
  input logic signed [mwsm_pkg::MOT_W-1:0] motor_b_o,
  input logic signed [mwsm_pkg::MOT_W-1:0] motor_c_o,
  input logic signed [mwsm_pkg::MOT_W-1:0] motor_d_o
);

  // Back-pressure only while the output register is full and held
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output side was free");

  // Reset empties the pipeline by the next edge
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(motor_a_o) &&
      $stable(motor_b_o) && $stable(motor_c_o) && $stable(motor_d_o)))
    else $error("stalled result changed or dropped");

endmodule

bind mecanum_wheel_speed_mixer mwsm_chk u_mwsm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .motor_a_o   (motor_a_o),
  .motor_b_o   (motor_b_o),
  .motor_c_o   (motor_c_o),
  .motor_d_o   (motor_d_o)
);
